### src/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the ping-pong delay
// Register map, gain formats, reset values and the lane control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

  localparam int DEPTH_DEF       = 131072;
  localparam int SAMPLE_BITS_DEF = 24;

  // Field widths of the register file.
  localparam int DELAY_W   = 17;
  localparam int FB_W      = 16;
  localparam int WET_W     = 17;
  localparam int GAIN_FRAC = 16;
  localparam int ROUND_HALF = 32768;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [FB_W-1:0]  FB_MAX  = 16'd64881;
  localparam logic [WET_W-1:0] WET_MAX = 17'd65536;

  localparam logic              ENABLE_RST = 1'b1;
  localparam int                DELAY_RST  = 12000;
  localparam logic [FB_W-1:0]   FB_RST     = 16'd32768;
  localparam logic [WET_W-1:0]  WET_RST    = 17'd32768;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_DELAY  = 2'd1,
    REG_FB     = 2'd2,
    REG_WET    = 2'd3
  } reg_idx_t;

  // Control word the top level hands to both lanes.
  typedef struct packed {
    logic rd_en;     // issue a line read for the word just accepted
    logic rd_valid;  // the entry being read has been written before
    logic bypass;    // the entry being read is written at this same edge
    logic s2_load;   // word moves from the read stage to the product stage
    logic wr_en;     // write the new line sample
  } lane_ctrl_t;

endpackage

`default_nettype wire

### src/ping_pong_delay.sv
// ----------------------------------------------------------------------------
// ping_pong_delay: stereo ping-pong feedback delay
// An accepted word passes through stage 1, stage 2 and the output register.
// A new word is taken only while stage 1 is empty and stage 2 is empty or
// retiring, set by the read-to-write span of each line memory.
// A delay write stalls the input while it is reduced modulo the line depth.
// Reset: registers return to their reset values; the lines read as zero
// until written, tracked by the write pointer, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module ping_pong_delay import ppd_pkg::*; #(
  parameter int DELAY_DEPTH = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel: one stereo frame per word.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  wire logic                          in_block_end,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [SAMPLE_BITS-1:0] out_left_out,
  output logic signed      [SAMPLE_BITS-1:0] out_right_out,
  output logic                               out_block_end_out,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic        [PADDR_W-1:0]     paddr,
  input  wire logic        [PDATA_W-1:0]     pwdata,
  output logic             [PDATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int SW  = SAMPLE_BITS;
  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int CW  = 2;
  // Reciprocal division of a delay value by the line depth: the scaled
  // reciprocal is exact for every delay that fits the register.
  localparam int SH  = DELAY_W + AW;
  localparam int RW  = DELAY_W + 2;
  localparam int PW  = DELAY_W + RW;
  localparam int QDW = DELAY_W + AW;

  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] DELAY_RST_RED = AW'(DELAY_RST % DELAY_DEPTH);

  localparam longint          RECIP_L = ((longint'(1) <<< SH) + longint'(DELAY_DEPTH) - 1)
                                        / longint'(DELAY_DEPTH);
  localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);
  localparam logic [QDW-1:0]  DEPTH_Q = QDW'(DELAY_DEPTH);

  // Steps of the delay reduction.
  localparam logic [CW-1:0]   MOD_QUOT = 2'd2;
  localparam logic [CW-1:0]   MOD_REM  = 2'd1;

  // --------------------------------------------------------------------------
  // Register file. Gains are clamped on write so the datapath never sees an
  // out-of-range value; the delay is kept raw for read-back and reduced to
  // a line offset in two steps: the quotient by a reciprocal multiply, then
  // the remainder by subtracting the quotient times the depth.
  // --------------------------------------------------------------------------
  logic              enable_r;
  logic [DELAY_W-1:0] delay_r;
  logic [FB_W-1:0]   fb_r;
  logic [WET_W-1:0]  wet_r;
  logic [DELAY_W-1:0] mod_src_r;
  logic [DELAY_W-1:0] mod_q_r;
  logic [AW-1:0]     mod_rem_r;
  logic [CW-1:0]     mod_cnt_r;
  logic              mod_busy;
  logic [PW-1:0]     mod_prod;
  logic [QDW-1:0]    mod_qd;
  logic [QDW-1:0]    mod_diff;

  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  logic [FB_W-1:0]   fb_wdata;
  logic [WET_W-1:0]  wet_wdata;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[3:2]);
  assign mod_busy = (mod_cnt_r != '0);

  always_comb begin
    fb_wdata  = (pwdata[FB_W-1:0] > FB_MAX) ? FB_MAX : pwdata[FB_W-1:0];
    wet_wdata = (pwdata[WET_W-1:0] > WET_MAX) ? WET_MAX : pwdata[WET_W-1:0];
    mod_prod  = PW'(mod_src_r) * PW'(RECIP);
    mod_qd    = QDW'(mod_q_r) * DEPTH_Q;
    mod_diff  = QDW'(mod_src_r) - mod_qd;
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE: prdata = PDATA_W'(enable_r);
      REG_DELAY:  prdata = PDATA_W'(delay_r);
      REG_FB:     prdata = PDATA_W'(fb_r);
      REG_WET:    prdata = PDATA_W'(wet_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= ENABLE_RST;
      delay_r   <= DELAY_W'(DELAY_RST);
      fb_r      <= FB_RST;
      wet_r     <= WET_RST;
      mod_src_r <= '0;
      mod_q_r   <= '0;
      mod_rem_r <= DELAY_RST_RED;
      mod_cnt_r <= '0;
    end else begin
      if (cfg_wr && (cfg_idx == REG_ENABLE)) begin
        enable_r <= pwdata[0];
      end
      if (cfg_wr && (cfg_idx == REG_FB)) begin
        fb_r <= fb_wdata;
      end
      if (cfg_wr && (cfg_idx == REG_WET)) begin
        wet_r <= wet_wdata;
      end
      // Quotient in the first cycle after the write, remainder in the next.
      if (cfg_wr && (cfg_idx == REG_DELAY)) begin
        delay_r   <= pwdata[DELAY_W-1:0];
        mod_src_r <= pwdata[DELAY_W-1:0];
        mod_cnt_r <= MOD_QUOT;
      end else if (mod_cnt_r == MOD_QUOT) begin
        mod_q_r   <= DELAY_W'(mod_prod >> SH);
        mod_cnt_r <= MOD_REM;
      end else if (mod_busy) begin
        mod_rem_r <= mod_diff[AW-1:0];
        mod_cnt_r <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline: stage 1 holds the accepted word while the line read returns,
  // stage 2 holds the products, and the output register holds the result.
  // A new word enters only when stage 1 is empty and stage 2 is empty or
  // retiring, so its read never runs ahead of the previous word's write;
  // when both fall on one edge the lanes forward the written sample.
  // --------------------------------------------------------------------------
  logic                 s1_vld_r;
  logic signed [SW-1:0] s1_left_r;
  logic signed [SW-1:0] s1_right_r;
  logic                 s1_be_r;
  logic [AW-1:0]        s1_wp_r;

  logic                 s2_vld_r;
  logic signed [SW-1:0] s2_left_r;
  logic signed [SW-1:0] s2_right_r;
  logic                 s2_be_r;
  logic [AW-1:0]        s2_wp_r;

  logic                 out_vld_r;
  logic signed [SW-1:0] out_left_r;
  logic signed [SW-1:0] out_right_r;
  logic                 out_be_r;

  logic [AW-1:0]        wp_r;
  logic                 wrap_r;

  logic                 s1_vld_nxt;
  logic                 s2_vld_nxt;
  logic                 out_vld_nxt;
  logic [AW-1:0]        wp_nxt;
  logic                 wrap_nxt;

  logic                 in_acc;
  logic                 out_free;
  logic                 s2_fire;
  logic                 s1_move;
  logic [AW:0]          rd_diff;
  logic [AW:0]          rd_wrapped;
  logic [AW-1:0]        rd_addr;
  lane_ctrl_t           lane_ctrl;

  logic signed [SW:0]   fb_left;
  logic signed [SW:0]   fb_right;
  logic signed [SW-1:0] mix_left;
  logic signed [SW-1:0] mix_right;
  logic signed [SW-1:0] wr_left;
  logic signed [SW-1:0] wr_right;

  assign out_free = !out_vld_r || !out_stall;
  assign s2_fire  = s2_vld_r && out_free;
  assign s1_move  = s1_vld_r && (!s2_vld_r || s2_fire);
  assign in_stall = s1_vld_r || (s2_vld_r && !s2_fire) || mod_busy;
  assign in_acc   = in_valid && !in_stall;

  // Read position trails the write pointer by the reduced delay. A zero
  // delay lands on the entry about to be overwritten, which is read first.
  // Before the pointer has wrapped, only entries below it hold data.
  always_comb begin
    rd_diff    = {1'b0, wp_r} - {1'b0, mod_rem_r};
    rd_wrapped = rd_diff + DEPTH_X;
    rd_addr    = rd_diff[AW] ? rd_wrapped[AW-1:0] : rd_diff[AW-1:0];

    lane_ctrl.rd_en    = in_acc && enable_r;
    lane_ctrl.rd_valid = wrap_r || (rd_addr < wp_r);
    lane_ctrl.bypass   = s2_fire && in_acc && enable_r && (rd_addr == s2_wp_r);
    lane_ctrl.s2_load  = s1_move;
    lane_ctrl.wr_en    = s2_fire && enable_r;
  end

  // Pointer moves only for frames that are processed.
  always_comb begin
    wp_nxt   = wp_r;
    wrap_nxt = wrap_r;
    if (in_acc && enable_r) begin
      if (wp_r == WP_LAST) begin
        wp_nxt   = '0;
        wrap_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_vld_nxt  = in_acc || (s1_vld_r && !s1_move);
    s2_vld_nxt  = s1_move || (s2_vld_r && !s2_fire);
    out_vld_nxt = s2_fire || (out_vld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      wp_r      <= '0;
      wrap_r    <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
      wp_r      <= wp_nxt;
      wrap_r    <= wrap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r  <= in_left_in;
      s1_right_r <= in_right_in;
      s1_be_r    <= in_block_end;
      s1_wp_r    <= wp_r;
    end
    if (s1_move) begin
      s2_left_r  <= s1_left_r;
      s2_right_r <= s1_right_r;
      s2_be_r    <= s1_be_r;
      s2_wp_r    <= s1_wp_r;
    end
    // A disabled block hands the frame through unchanged.
    if (s2_fire) begin
      out_left_r  <= enable_r ? mix_left : s2_left_r;
      out_right_r <= enable_r ? mix_right : s2_right_r;
      out_be_r    <= s2_be_r;
    end
  end

  ppd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (s2_wp_r),
    .wr_data  (wr_left),
    .dry_s1   (s1_left_r),
    .dry_s2   (s2_left_r),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .fb_term  (fb_left),
    .mix_out  (mix_left)
  );

  ppd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (s2_wp_r),
    .wr_data  (wr_right),
    .dry_s1   (s1_right_r),
    .dry_s2   (s2_right_r),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .fb_term  (fb_right),
    .mix_out  (mix_right)
  );

  ppd_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .left          (s2_left_r),
    .right         (s2_right_r),
    .fb_from_left  (fb_left),
    .fb_from_right (fb_right),
    .left_wr       (wr_left),
    .right_wr      (wr_right)
  );

  assign out_valid         = out_vld_r;
  assign out_left_out      = out_left_r;
  assign out_right_out     = out_right_r;
  assign out_block_end_out = out_be_r;

  // --------------------------------------------------------------------------
  // Checks on the pipeline spacing and the line bookkeeping.
  // --------------------------------------------------------------------------

  // Forwarding is only ever chosen when a write and a read share the edge.
  a_bypass_pair: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctrl.bypass |-> (lane_ctrl.wr_en && lane_ctrl.rd_en))
    else $error("forwarding selected without a same-edge write and read");

  // After an accept, the new word sits alone ahead of the product stage.
  a_accept_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (s1_vld_r && !s2_vld_r))
    else $error("accepted word overlaps a word still ahead of its write");

  // Once every entry has been written, it stays written.
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_r |=> wrap_r)
    else $error("line fill flag cleared outside reset");

  // A retiring word always lands in the output register.
  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> out_vld_r)
    else $error("retired word lost before the output register");

  // The reduced delay is a valid line offset whenever words may enter.
  a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
    !mod_busy |-> ({1'b0, mod_rem_r} < DEPTH_X))
    else $error("reduced delay outside the line depth");

endmodule

`default_nettype wire

### src/ppd_ram.sv
// ----------------------------------------------------------------------------
// ppd_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/ppd_lane.sv
// ----------------------------------------------------------------------------
// ppd_lane: one channel of the ping-pong delay
// Holds the channel's delay line, picks the delayed sample and forms the
// feedback term and the wet/dry mix for that channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_lane import ppd_pkg::*; #(
  parameter int DELAY_DEPTH = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire lane_ctrl_t                           ctrl,
  input  wire logic        [$clog2(DELAY_DEPTH)-1:0] rd_addr,
  input  wire logic        [$clog2(DELAY_DEPTH)-1:0] wr_addr,
  input  wire logic signed [SAMPLE_BITS-1:0]        wr_data,
  input  wire logic signed [SAMPLE_BITS-1:0]        dry_s1,
  input  wire logic signed [SAMPLE_BITS-1:0]        dry_s2,
  input  wire logic        [FB_W-1:0]               fb_gain,
  input  wire logic        [WET_W-1:0]              wet_gain,
  output logic signed      [SAMPLE_BITS:0]          fb_term,
  output logic signed      [SAMPLE_BITS-1:0]        mix_out
);

  localparam int SW     = SAMPLE_BITS;
  localparam int PW_FB  = SW + FB_W + 1;
  localparam int PW_MIX = SW + WET_W + 2;
  localparam int ACC_W  = PW_MIX + 1;
  localparam int HI_W   = ACC_W - GAIN_FRAC;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW-1:0]            ram_q;
  logic                     rd_valid_r;
  logic                     bypass_r;
  logic signed [SW-1:0]     fwd_r;
  logic signed [SW-1:0]     dly;
  logic signed [SW:0]       diff;
  logic signed [PW_FB-1:0]  fb_prod_nxt;
  logic signed [PW_FB-1:0]  fb_prod_r;
  logic signed [PW_MIX-1:0] mix_prod_nxt;
  logic signed [PW_MIX-1:0] mix_prod_r;
  logic signed [PW_FB-1:0]  fb_sum;
  logic        [ACC_W-1:0]  acc;
  logic        [HI_W-1:0]   acc_hi;
  logic        [HI_W-SW:0]  acc_top;

  ppd_ram #(
    .W     (SW),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctrl.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // The forward register keeps the last written sample so that a read of
  // the very entry written at the same edge sees the new value.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_valid_r <= ctrl.rd_valid;
      bypass_r   <= ctrl.bypass;
    end
    if (ctrl.wr_en) begin
      fwd_r <= wr_data;
    end
    if (ctrl.s2_load) begin
      fb_prod_r  <= fb_prod_nxt;
      mix_prod_r <= mix_prod_nxt;
    end
  end

  always_comb begin
    if (bypass_r) begin
      dly = fwd_r;
    end else if (rd_valid_r) begin
      dly = $signed(ram_q);
    end else begin
      dly = '0;
    end
    diff         = $signed({dly[SW-1], dly}) - $signed({dry_s1[SW-1], dry_s1});
    fb_prod_nxt  = PW_FB'(dly) * PW_FB'($signed({1'b0, fb_gain}));
    mix_prod_nxt = PW_MIX'(diff) * PW_MIX'($signed({1'b0, wet_gain}));
  end

  // dry * 1.0 + (wet - dry) * gain, rounded half up, then saturated.
  always_comb begin
    fb_sum  = fb_prod_r + PW_FB'(ROUND_HALF);
    fb_term = fb_sum[PW_FB-1:GAIN_FRAC];
    acc     = {{(ACC_W-SW-GAIN_FRAC){dry_s2[SW-1]}}, dry_s2, {GAIN_FRAC{1'b0}}}
              + {mix_prod_r[PW_MIX-1], mix_prod_r}
              + ACC_W'(ROUND_HALF);
    acc_hi  = acc[ACC_W-1:GAIN_FRAC];
    acc_top = acc_hi[HI_W-1:SW-1];
    if ((&acc_top) || (~|acc_top)) begin
      mix_out = $signed(acc_hi[SW-1:0]);
    end else if (acc_hi[HI_W-1]) begin
      mix_out = $signed(S_MIN);
    end else begin
      mix_out = $signed(S_MAX);
    end
  end

endmodule

`default_nettype wire

### src/ppd_merge.sv
// ----------------------------------------------------------------------------
// ppd_merge: cross-feed of the two lanes
// Forms the mono average and adds the feedback term of the opposite lane,
// saturating the new line samples.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_merge import ppd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic signed [SAMPLE_BITS-1:0] left,
  input  wire logic signed [SAMPLE_BITS-1:0] right,
  input  wire logic signed [SAMPLE_BITS:0]   fb_from_left,
  input  wire logic signed [SAMPLE_BITS:0]   fb_from_right,
  output logic signed      [SAMPLE_BITS-1:0] left_wr,
  output logic signed      [SAMPLE_BITS-1:0] right_wr
);

  localparam int SW = SAMPLE_BITS;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic [SW:0]   pair_sum;
  logic [SW-1:0] mono;
  logic [SW+1:0] left_sum;
  logic [SW+1:0] right_sum;

  function automatic logic [SW-1:0] clip(input logic [SW+1:0] v);
    logic [2:0] top;
    top = v[SW+1:SW-1];
    if ((&top) || (~|top)) begin
      return v[SW-1:0];
    end else if (v[SW+1]) begin
      return S_MIN;
    end else begin
      return S_MAX;
    end
  endfunction

  // The left line is fed from the right delayed sample and vice versa.
  always_comb begin
    pair_sum  = {left[SW-1], left} + {right[SW-1], right};
    mono      = pair_sum[SW:1];
    left_sum  = {{2{mono[SW-1]}}, mono} + {fb_from_right[SW], fb_from_right};
    right_sum = {{2{mono[SW-1]}}, mono} + {fb_from_left[SW], fb_from_left};
    left_wr   = $signed(clip(left_sum));
    right_wr  = $signed(clip(right_sum));
  end

endmodule

`default_nettype wire
